@@ hw/rtl/dqc_pkg.sv @@
// Shared constants, request and status codes, and the controller-to-datapath
// command type for the double-ended queue with cursor. Depends on nothing.
`default_nettype none

package dqc_pkg;

	// Ring store depth; legal range 2 to 4096.
	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int KIND_W = 4;
	localparam int STAT_W = 2;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_PUSH_L = 4'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_R = 4'd1;
	localparam logic [KIND_W-1:0] KIND_POP_L  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_POP_R  = 4'd3;
	localparam logic [KIND_W-1:0] KIND_CUR_L  = 4'd4;
	localparam logic [KIND_W-1:0] KIND_CUR_R  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_GET    = 4'd6;
	localparam logic [KIND_W-1:0] KIND_SET    = 4'd7;
	localparam logic [KIND_W-1:0] KIND_PEEK_L = 4'd8;
	localparam logic [KIND_W-1:0] KIND_PEEK_R = 4'd9;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_END   = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;  // latch the request and read its slot
		logic commit;  // update pointers and store, load the output register
	} dqc_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/dqc_ctrl.sv @@
// Handshake controller for the deque: two-state sequencer and output valid.
// Depends on dqc_pkg.
`default_nettype none

module dqc_ctrl import dqc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	output dqc_cmd_t      cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.accept = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit = (state_q == ST_EXEC) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dqc_dpath.sv @@
// Datapath of the deque: ring store, end and cursor pointers, request
// evaluation and the output register. Depends on dqc_pkg.
`default_nettype none

module dqc_dpath import dqc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dqc_cmd_t                 cmd,
	input  wire logic [KIND_W-1:0]        kind,
	input  wire logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0]      data,
	output logic [STAT_W-1:0]             status,
	output logic [CNT_W-1:0]              count,
	output logic                          is_empty
);

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] i,
	                                             input logic [CNT_W-1:0] n);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(i) + (CNT_W+1)'(n);
		if (s >= (CNT_W+1)'(DEPTH)) s = s - (CNT_W+1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	logic signed [DATA_W-1:0] slots_q [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;
	logic [IDX_W-1:0]         left_q;
	logic [IDX_W-1:0]         cursor_q;
	logic [CNT_W-1:0]         fill_q;
	logic [KIND_W-1:0]        kind_s1;
	logic signed [DATA_W-1:0] value_s1;

	logic [IDX_W-1:0]         right_c;
	logic [IDX_W-1:0]         rd_addr;
	logic                     empty_c;

	logic [IDX_W-1:0]         left_d;
	logic [IDX_W-1:0]         cursor_d;
	logic [CNT_W-1:0]         fill_d;
	logic signed [DATA_W-1:0] data_d;
	logic [STAT_W-1:0]        status_d;
	logic                     we_c;
	logic [IDX_W-1:0]         waddr_c;

	logic signed [DATA_W-1:0] data_q;
	logic [STAT_W-1:0]        status_q;
	logic [CNT_W-1:0]         count_q;
	logic                     is_empty_q;

	assign right_c = wrap_add(left_q, fill_q - 1'b1);
	assign empty_c = (fill_q == '0);

	// Read address chosen from the incoming request.
	always_comb begin
		case (kind) inside
			KIND_POP_L, KIND_PEEK_L: rd_addr = left_q;
			KIND_POP_R, KIND_PEEK_R: rd_addr = right_c;
			default:                 rd_addr = cursor_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_data_q <= slots_q[rd_addr];
			kind_s1   <= kind;
			value_s1  <= value;
		end
		if (we_c) begin
			slots_q[waddr_c] <= value_s1;
		end
	end

	always_comb begin
		left_d   = left_q;
		cursor_d = cursor_q;
		fill_d   = fill_q;
		data_d   = '0;
		status_d = STAT_OK;
		we_c     = 1'b0;
		waddr_c  = wrap_add(left_q, fill_q);
		unique case (kind_s1) inside
			KIND_PUSH_L, KIND_PUSH_R: begin
				if (fill_q == CNT_W'(DEPTH)) begin
					status_d = STAT_FULL;
				end else begin
					if (kind_s1 == KIND_PUSH_L) begin
						left_d  = wrap_dec(left_q);
						waddr_c = left_d;
					end
					we_c   = cmd.commit;
					fill_d = fill_q + 1'b1;
					if (empty_c) cursor_d = waddr_c;
				end
			end
			KIND_POP_L, KIND_POP_R, KIND_CUR_L, KIND_CUR_R, KIND_GET, KIND_SET,
			KIND_PEEK_L, KIND_PEEK_R: begin
				if (empty_c) begin
					status_d = STAT_EMPTY;
				end else begin
					unique case (kind_s1)
						KIND_POP_L: begin
							data_d = rd_data_q;
							if (cursor_q == left_q) cursor_d = wrap_inc(left_q);
							left_d = wrap_inc(left_q);
							fill_d = fill_q - 1'b1;
							if (fill_d == '0) cursor_d = '0;
						end
						KIND_POP_R: begin
							data_d = rd_data_q;
							if (cursor_q == right_c) cursor_d = wrap_dec(right_c);
							fill_d = fill_q - 1'b1;
							if (fill_d == '0) cursor_d = '0;
						end
						KIND_CUR_L: begin
							if (cursor_q == left_q) status_d = STAT_END;
							else cursor_d = wrap_dec(cursor_q);
						end
						KIND_CUR_R: begin
							if (cursor_q == right_c) status_d = STAT_END;
							else cursor_d = wrap_inc(cursor_q);
						end
						KIND_SET: begin
							we_c    = cmd.commit;
							waddr_c = cursor_q;
						end
						default: data_d = rd_data_q;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			cursor_q <= '0;
			fill_q   <= '0;
		end else if (cmd.commit) begin
			left_q   <= left_d;
			cursor_q <= cursor_d;
			fill_q   <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			data_q     <= data_d;
			status_q   <= status_d;
			count_q    <= fill_d;
			is_empty_q <= (fill_d == '0);
		end
	end

	assign data     = data_q;
	assign status   = status_q;
	assign count    = count_q;
	assign is_empty = is_empty_q;

endmodule

`default_nettype wire

@@ hw/rtl/deque_with_cursor.sv @@
// Top level of the bounded double-ended queue with cursor.
// Depends on dqc_pkg, dqc_ctrl and dqc_dpath.
//
// Each input item is one request (push or pop at either end, move the cursor,
// read or overwrite the cursor element, peek at an end) and yields exactly one
// result item carrying data, status, the element count after the request and
// an empty flag. An item is handled in an accept step and a commit step. In
// the accept cycle the slot it needs is read from the ring store, whose read
// port is registered; in the commit the pointers, the cursor and the store
// are updated and the result is loaded into the output register. No new
// item is taken until the previous one has committed, but one is taken while
// the previous result still waits in the output register; the commit waits
// only when that register is still held by a stalled result. Requests that
// fail (empty queue, full queue, cursor at an end) report a status and
// change nothing; unused kinds return status ok and change nothing.
`default_nettype none

module deque_with_cursor import dqc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [KIND_W-1:0]        kind,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      data,
	output logic [STAT_W-1:0]             status,
	output logic [CNT_W-1:0]              count,
	output logic                          is_empty
);

	dqc_cmd_t cmd;

	// The controller sequences accept and commit and owns the output valid.
	dqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// The datapath holds the store, the pointers and the result register.
	dqc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.kind     (kind),
		.value    (value),
		.data     (data),
		.status   (status),
		.count    (count),
		.is_empty (is_empty)
	);

endmodule

`default_nettype wire

@@ hw/rtl/dqc_checker.sv @@
// Port-level checks for deque_with_cursor and the bind that attaches them.
// Depends on dqc_pkg.
`default_nettype none

module dqc_checker import dqc_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic signed [DATA_W-1:0] data,
	input wire logic [STAT_W-1:0]        status,
	input wire logic [CNT_W-1:0]         count,
	input wire logic                     is_empty
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data) && $stable(status)
			&& $stable(count))
		else $error("stalled result changed");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)) && (count <= CNT_W'(DEPTH)))
		else $error("count and empty flag disagree");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> count == CNT_W'(DEPTH) && data == '0)
		else $error("full status with queue not full");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> is_empty && data == '0)
		else $error("empty status with queue not empty");

endmodule

bind deque_with_cursor dqc_checker u_dqc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.data      (data),
	.status    (status),
	.count     (count),
	.is_empty  (is_empty)
);

`default_nettype wire

@@ sim/deque_with_cursor_test.sv @@
// Self-checking testbench for deque_with_cursor: random requests with idle and stall gaps.
// A local ring-store model predicts every result, which is checked in order.
// Depends on dqc_pkg and deque_with_cursor.
module deque_with_cursor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dqc_pkg::*;

	// Kinds 10 to 15 carry no operation; the block answers them and changes nothing.
	localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
	localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

	localparam int RANDOM_ITEMS = 700;
	localparam int IDLE_PCT     = 11;
	// No idling on either side during this window of cycles.
	localparam int QUIET_FROM   = 300;
	localparam int QUIET_TO     = 900;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic [KIND_W-1:0]        op;
		logic signed [DATA_W-1:0] operand;
	} deque_request_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [STAT_W-1:0]        status;
		logic [CNT_W-1:0]         count;
		logic                     is_empty;
	} deque_result_t;

	// Request mixes for the random part: growing runs reach the full queue,
	// shrinking runs reach the empty one.
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} request_mix_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [KIND_W-1:0]        kind = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] data;
	logic [STAT_W-1:0]        status;
	logic [CNT_W-1:0]         count;
	logic                     is_empty;

	deque_request_t pending_requests[$];
	deque_result_t  expected_results[$];
	int             error_count = 0;
	int             cycle_count = 0;

	// Model of the ring store, its left end, its fill level and the cursor.
	logic signed [DATA_W-1:0] ring_slots [DEPTH];
	logic [IDX_W-1:0]         ring_left = '0;
	logic [CNT_W-1:0]         ring_fill = '0;
	logic [IDX_W-1:0]         ring_cursor = '0;

	deque_with_cursor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data      (data),
		.status    (status),
		.count     (count),
		.is_empty  (is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic take_break();
		if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	function automatic logic [IDX_W-1:0] slot_up(input logic [IDX_W-1:0] i);
		return (int'(i) == DEPTH - 1) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] slot_down(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	// Slot that lies n places right of the left end.
	function automatic logic [IDX_W-1:0] slot_from_left(input int n);
		return IDX_W'((int'(ring_left) + n) % DEPTH);
	endfunction

	// Applies one request to the model and returns the result it must give.
	function automatic deque_result_t apply_request(input logic [KIND_W-1:0] op,
			input logic signed [DATA_W-1:0] operand);
		deque_result_t    res;
		logic [IDX_W-1:0] slot;
		res = '0;
		if (op == KIND_PUSH_L || op == KIND_PUSH_R) begin
			if (int'(ring_fill) >= DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				if (op == KIND_PUSH_L) begin
					ring_left = slot_down(ring_left);
					slot = ring_left;
				end else begin
					slot = slot_from_left(int'(ring_fill));
				end
				ring_slots[slot] = operand;
				// The first element of an empty queue takes the cursor.
				if (ring_fill == '0)
					ring_cursor = slot;
				ring_fill = ring_fill + 1'b1;
			end
		end else if (op <= KIND_PEEK_R) begin
			if (ring_fill == '0) begin
				res.status = STAT_EMPTY;
			end else begin
				slot = slot_from_left(int'(ring_fill) - 1);
				case (op)
					KIND_POP_L: begin
						res.data = ring_slots[ring_left];
						if (ring_cursor == ring_left)
							ring_cursor = slot_up(ring_left);
						ring_left = slot_up(ring_left);
						ring_fill = ring_fill - 1'b1;
						if (ring_fill == '0)
							ring_cursor = '0;
					end
					KIND_POP_R: begin
						res.data = ring_slots[slot];
						if (ring_cursor == slot)
							ring_cursor = slot_down(slot);
						ring_fill = ring_fill - 1'b1;
						if (ring_fill == '0)
							ring_cursor = '0;
					end
					KIND_CUR_L: begin
						if (ring_cursor == ring_left)
							res.status = STAT_END;
						else
							ring_cursor = slot_down(ring_cursor);
					end
					KIND_CUR_R: begin
						if (ring_cursor == slot)
							res.status = STAT_END;
						else
							ring_cursor = slot_up(ring_cursor);
					end
					KIND_GET:    res.data = ring_slots[ring_cursor];
					KIND_SET:    ring_slots[ring_cursor] = operand;
					KIND_PEEK_L: res.data = ring_slots[ring_left];
					default:     res.data = ring_slots[slot];
				endcase
			end
		end
		res.count = ring_fill;
		res.is_empty = (ring_fill == '0);
		return res;
	endfunction

	// Driver: a presented item is held until it is taken, then the next one
	// is loaded unless this cycle is an idle one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_request(kind, value));
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && !take_break()) begin
					in_valid <= 1'b1;
					kind <= pending_requests[0].op;
					value <= pending_requests[0].operand;
					void'(pending_requests.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every taken result is compared with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%t: result with none expected: data %0d status %0d count %0d",
						$time, data, status, count);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (data !== want.data) begin
						$display("%t: data expected %0d, got %0d", $time, want.data, data);
						error_count++;
					end
					if (status !== want.status) begin
						$display("%t: status expected %0d, got %0d", $time, want.status, status);
						error_count++;
					end
					if (count !== want.count) begin
						$display("%t: count expected %0d, got %0d", $time, want.count, count);
						error_count++;
					end
					if (is_empty !== want.is_empty) begin
						$display("%t: is_empty expected %0d, got %0d",
							$time, want.is_empty, is_empty);
						error_count++;
					end
				end
			end
			out_stall <= take_break();
		end
	end

	task automatic queue_request(input logic [KIND_W-1:0] op,
			input logic signed [DATA_W-1:0] operand);
		deque_request_t req;
		req.op = op;
		req.operand = operand;
		pending_requests.push_back(req);
	endtask

	// Mostly random values, with the extremes now and then.
	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(99) >= 10)
			return $urandom;
		case ($urandom_range(3))
			0:       return '0;
			1:       return {1'b1, {(DATA_W-1){1'b0}}};
			2:       return {1'b0, {(DATA_W-1){1'b1}}};
			default: return '1;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(input request_mix_t mix);
		int roll;
		int push_pct;
		int pop_pct;
		roll = $urandom_range(99);
		case (mix)
			MIX_GROW:   begin push_pct = 60; pop_pct = 10; end
			MIX_SHRINK: begin push_pct = 15; pop_pct = 55; end
			default:    begin push_pct = 30; pop_pct = 30; end
		endcase
		if (roll < push_pct)
			return $urandom_range(1) ? KIND_PUSH_R : KIND_PUSH_L;
		if (roll < push_pct + pop_pct)
			return $urandom_range(1) ? KIND_POP_R : KIND_POP_L;
		case ($urandom_range(5))
			0:       return KIND_CUR_L;
			1:       return KIND_CUR_R;
			2:       return KIND_GET;
			3:       return KIND_SET;
			4:       return KIND_PEEK_L;
			default: return KIND_PEEK_R;
		endcase
	endfunction

	initial begin
		request_mix_t mix;
		int           counted;
		int           run_len;

		// Every request that needs an element, made on the empty queue.
		for (int k = int'(KIND_POP_L); k <= int'(KIND_PEEK_R); k++)
			queue_request(KIND_W'(k), $urandom);
		queue_request(KIND_UNUSED_LO, '1);
		queue_request(KIND_UNUSED_HI, '0);
		// The first push places the cursor on the new element.
		queue_request(KIND_PUSH_L, {1'b1, {(DATA_W-1){1'b0}}});
		queue_request(KIND_PUSH_R, {1'b0, {(DATA_W-1){1'b1}}});
		// Cursor moves into both ends of a two-element queue.
		queue_request(KIND_CUR_L, '0);
		queue_request(KIND_CUR_R, '0);
		queue_request(KIND_CUR_R, '0);
		queue_request(KIND_GET, '0);
		queue_request(KIND_SET, '1);
		queue_request(KIND_PEEK_L, '0);
		queue_request(KIND_PEEK_R, '0);
		// Popping the element under the cursor pushes the cursor inward,
		// and popping the last element clears it.
		queue_request(KIND_POP_R, '0);
		queue_request(KIND_GET, '0);
		queue_request(KIND_POP_L, '0);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			mix = request_mix_t'($urandom_range(2));
			run_len = $urandom_range(10, 40);
			repeat (run_len) begin
				if ($urandom_range(99) < 2) begin
					queue_request(KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
						pick_value());
				end else begin
					queue_request(pick_kind(mix), pick_value());
					counted++;
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("deque_with_cursor_test: done, clean");
		else
			$display("deque_with_cursor_test: done, errors");
		$finish;
	end

	// A correct run needs well under a tenth of this time.
	initial begin
		#500_000;
		$display("%t: timeout", $time);
		$display("deque_with_cursor_test: done, errors");
		$finish;
	end

endmodule
